### sv/afc_pkg.sv
// Shared types and constants for the autorange frequency counter.
// No dependencies; imported by every module of the block.
package afc_pkg;

  localparam int GATE_BITS  = 8;
  localparam int THR_BITS   = 16;
  localparam int SCALE_BITS = 8;
  localparam int VALUE_BITS = 40;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [GATE_BITS-1:0]  FAST_GATE_RST = 8'd20;
  localparam logic [GATE_BITS-1:0]  SLOW_GATE_RST = 8'd100;
  localparam logic [THR_BITS-1:0]   LOW_THR_RST   = 16'd2;
  localparam logic [THR_BITS-1:0]   HIGH_THR_RST  = 16'd16;
  localparam logic [SCALE_BITS-1:0] SLOW_SCALE_RST = 8'd200;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FAST_GATE  = 3'd0,
    CFG_SLOW_GATE  = 3'd1,
    CFG_LOW_THR    = 3'd2,
    CFG_HIGH_THR   = 3'd3,
    CFG_SLOW_SCALE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_MEAS   = 2'd0,
    KIND_TO_MHZ = 2'd1,
    KIND_TO_HZ  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [GATE_BITS-1:0]  fast_gate;
    logic [GATE_BITS-1:0]  slow_gate;
    logic [THR_BITS-1:0]   low_thr;
    logic [THR_BITS-1:0]   high_thr;
    logic [SCALE_BITS-1:0] slow_scale;
  } cfg_t;

  typedef struct packed {
    kind_e                 kind;
    logic                  milli;
    logic [VALUE_BITS-1:0] value;
  } res_t;

endpackage

### sv/afc_cfg.sv
// Configuration register file of the autorange frequency counter.
// Depends on afc_pkg for the register layout and index codes.
module afc_cfg import afc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FAST_GATE:  cfg_d.fast_gate  = cfg_data_i[GATE_BITS-1:0];
        CFG_SLOW_GATE:  cfg_d.slow_gate  = cfg_data_i[GATE_BITS-1:0];
        CFG_LOW_THR:    cfg_d.low_thr    = cfg_data_i[THR_BITS-1:0];
        CFG_HIGH_THR:   cfg_d.high_thr   = cfg_data_i[THR_BITS-1:0];
        CFG_SLOW_SCALE: cfg_d.slow_scale = cfg_data_i[SCALE_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_gate  <= FAST_GATE_RST;
      cfg_q.slow_gate  <= SLOW_GATE_RST;
      cfg_q.low_thr    <= LOW_THR_RST;
      cfg_q.high_thr   <= HIGH_THR_RST;
      cfg_q.slow_scale <= SLOW_SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/afc_core.sv
// Counter state and gate-end judgment: edge counter, gate countdown, range flag.
// Depends on afc_pkg for cfg_t, res_t and kind codes.
module afc_core import afc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  logic edge_i,
  input  logic tick_i,
  input  cfg_t cfg_i,
  output logic fire_o,
  output res_t res_o
);

  localparam int PW = COUNT_BITS + SCALE_BITS;
  localparam int EW = (PW > VALUE_BITS) ? PW : VALUE_BITS + 1;

  logic [COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic [GATE_BITS-1:0]  ticks_q, ticks_d;
  logic                  slow_q, slow_new, slow_d;
  logic                  gate_end;
  logic [PW-1:0]         prod;
  logic [EW-1:0]         val_ext;
  kind_e                 kind;

  assign count_inc = (edge_i && !(&count_q)) ? count_q + 1'b1 : count_q;
  assign gate_end  = tick_i && (ticks_q <= GATE_BITS'(1));
  assign prod      = PW'(count_inc) * PW'(cfg_i.slow_scale);

  always_comb begin
    slow_new = slow_q;
    kind     = KIND_MEAS;
    val_ext  = '0;
    if (count_inc < COUNT_BITS'(cfg_i.low_thr)) begin
      slow_new = 1'b1;
      kind     = KIND_TO_MHZ;
    end else if (slow_q && (count_inc > COUNT_BITS'(cfg_i.high_thr))) begin
      slow_new = 1'b0;
      kind     = KIND_TO_HZ;
    end else if (slow_q) begin
      val_ext = EW'(prod);
    end else begin
      val_ext = EW'(count_inc);
    end
  end

  always_comb begin
    count_d = count_q;
    ticks_d = ticks_q;
    slow_d  = slow_q;
    if (step_i) begin
      count_d = count_inc;
      if (tick_i) begin
        if (gate_end) begin
          count_d = '0;
          slow_d  = slow_new;
          ticks_d = slow_new ? cfg_i.slow_gate : cfg_i.fast_gate;
        end else begin
          ticks_d = ticks_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ticks_q <= FAST_GATE_RST;
      slow_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ticks_q <= ticks_d;
      slow_q  <= slow_d;
    end
  end

  assign fire_o      = gate_end;
  assign res_o.kind  = kind;
  assign res_o.milli = slow_new;
  assign res_o.value = (|val_ext[EW-1:VALUE_BITS]) ? {VALUE_BITS{1'b1}}
                                                  : val_ext[VALUE_BITS-1:0];

endmodule

### sv/afc_out.sv
// Result register of the autorange frequency counter, master stream side.
// Depends on afc_pkg for res_t.
module afc_out import afc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  res_t                  res_i,
  output logic                  free_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [VALUE_BITS-1:0] m_axis_tdata,  // [39:0] value
  output logic [2:0]            m_axis_tuser   // [1:0] report_kind, [2] in_millihertz
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || m_axis_tready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.value;
  assign m_axis_tuser  = {res_q.milli, res_q.kind};

endmodule

### sv/autorange_frequency_counter_top.sv
// Autorange gated frequency counter, top level: input register, core, result register.
// Throughput: one input transaction per cycle, but a gate-ending one waits in the input
// register until the result register is free; the result register frees as it is taken.
// Reset (rst_ni low, async): counter 0, countdown 20, Hz range, registers at defaults.
// Depends on afc_pkg, afc_cfg, afc_core and afc_out.
module autorange_frequency_counter_top import afc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [0] signal_edge, [1] gate_tick, [7:2] zero
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [VALUE_BITS-1:0]    m_axis_tdata,  // [39:0] value
  output logic [2:0]               m_axis_tuser   // [1:0] report_kind, [2] in_millihertz
);

  cfg_t cfg;
  res_t res;
  logic fire, out_free, advance;
  logic in_valid_q, in_valid_d;
  logic in_edge_q, in_tick_q;

  assign advance       = in_valid_q && (!fire || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) ? 1'b1
                       : (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_edge_q <= s_axis_tdata[0];
      in_tick_q <= s_axis_tdata[1];
    end
  end

  afc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  afc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .edge_i (in_edge_q),
    .tick_i (in_tick_q),
    .cfg_i  (cfg),
    .fire_o (fire),
    .res_o  (res)
  );

  afc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && fire),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### sv/afc_checker.sv
// Port-level checks for the autorange frequency counter, bound to the top level.
// Depends on afc_pkg for kind codes and widths.
module afc_checker import afc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [VALUE_BITS-1:0] m_axis_tdata,
  input logic [2:0]            m_axis_tuser
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_change_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != KIND_MEAS) |-> m_axis_tdata == '0)
    else $error("range change report carries a value");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[1:0] != KIND_TO_MHZ || m_axis_tuser[2])
                   && (m_axis_tuser[1:0] != KIND_TO_HZ || !m_axis_tuser[2]))
    else $error("range flag disagrees with switch report");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[1:0] != 2'b11)
    else $error("undefined report kind");

endmodule

bind autorange_frequency_counter_top afc_checker u_afc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### verif/autorange_frequency_counter_top_test.sv
// Self-checking testbench for autorange_frequency_counter_top.
// Predicts every gate report in-line and checks the stream output field by field.
// Depends on afc_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module autorange_frequency_counter_top_test import afc_pkg::*;;

  localparam int CNT_BITS     = 32;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LAST  = 3'd7;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [CNT_BITS-1:0]   CNT_MAX   = '1;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;  // [0] signal_edge, [1] gate_tick
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [VALUE_BITS-1:0]    m_axis_tdata;       // [39:0] value
  logic [2:0]               m_axis_tuser;       // [1:0] report_kind, [2] in_millihertz

  autorange_frequency_counter_top #(
    .COUNT_BITS(CNT_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predicted block state and registers
  logic [CNT_BITS-1:0]   edge_total = '0;
  logic [GATE_BITS-1:0]  ticks_rem  = FAST_GATE_RST;
  logic                  slow_mode  = 1'b0;
  logic [GATE_BITS-1:0]  gate_fast  = FAST_GATE_RST;
  logic [GATE_BITS-1:0]  gate_slow  = SLOW_GATE_RST;
  logic [THR_BITS-1:0]   thr_low    = LOW_THR_RST;
  logic [THR_BITS-1:0]   thr_high   = HIGH_THR_RST;
  logic [SCALE_BITS-1:0] milli_scale = SLOW_SCALE_RST;

  res_t        reports_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one accepted sample: count the edge, then run the gate countdown
  function automatic void gate_predict(input bit sig_edge, input bit tick);
    res_t        rep;
    logic [63:0] scaled;
    if (sig_edge && edge_total != CNT_MAX) edge_total = edge_total + 1'b1;
    if (!tick) return;
    if (ticks_rem > 1) begin
      ticks_rem = ticks_rem - 1'b1;
      return;
    end
    rep.kind  = KIND_MEAS;
    rep.value = '0;
    if (edge_total < thr_low) begin
      slow_mode = 1'b1;
      rep.kind  = KIND_TO_MHZ;
    end else if (slow_mode && edge_total > thr_high) begin
      slow_mode = 1'b0;
      rep.kind  = KIND_TO_HZ;
    end else if (slow_mode) begin
      scaled    = 64'(edge_total) * 64'(milli_scale);
      rep.value = (scaled > 64'(VALUE_MAX)) ? VALUE_MAX : scaled[VALUE_BITS-1:0];
    end else begin
      rep.value = VALUE_BITS'(edge_total);
    end
    rep.milli  = slow_mode;
    edge_total = '0;
    ticks_rem  = slow_mode ? gate_slow : gate_fast;
    reports_due.push_back(rep);
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic int unsigned tx_gap();
    return tx_quiet ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic send_sample(input bit sig_edge, input bit tick, input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, tick, sig_edge};
    do @(posedge clk_i); while (!s_axis_tready);
    gate_predict(sig_edge, tick);
  endtask

  // stop sending, let every report arrive, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_FAST_GATE:  gate_fast   = data[GATE_BITS-1:0];
      CFG_SLOW_GATE:  gate_slow   = data[GATE_BITS-1:0];
      CFG_LOW_THR:    thr_low     = data[THR_BITS-1:0];
      CFG_HIGH_THR:   thr_high    = data[THR_BITS-1:0];
      CFG_SLOW_SCALE: milli_scale = data[SCALE_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // receive side: random stall per transaction, check against oldest prediction
  initial begin
    res_t                  want;
    logic [1:0]            got_kind;
    logic                  got_milli;
    logic [VALUE_BITS-1:0] got_value;
    int unsigned           stall;
    @(posedge rst_ni);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_kind  = m_axis_tuser[1:0];
      got_milli = m_axis_tuser[2];
      got_value = m_axis_tdata;
      if (reports_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected report kind %0d milli %0d value %0d",
                                got_kind, got_milli, got_value));
      end else begin
        want = reports_due.pop_front();
        if (got_kind !== want.kind)
          flag_mismatch($sformatf("kind exp %0d got %0d", want.kind, got_kind));
        if (got_milli !== want.milli)
          flag_mismatch($sformatf("milli exp %0d got %0d", want.milli, got_milli));
        if (got_value !== want.value)
          flag_mismatch($sformatf("value exp %0d got %0d", want.value, got_value));
      end
    end
  end

  // default registers: one Hz gate of 20 ticks with an edge on each tick sample, then one idle sample
  task automatic test_defaults();
    repeat (20) send_sample(1'b1, 1'b1, tx_gap());
    send_sample(1'b0, 1'b0, tx_gap());
  endtask

  // range switches, repeated mHz switch, zero gate length, ignored indexes
  task automatic test_directed();
    drain();
    cfg_write(CFG_FAST_GATE, 16'd1);
    cfg_write(CFG_SLOW_GATE, 16'd0);
    cfg_write(CFG_LOW_THR, 16'd2);
    cfg_write(CFG_HIGH_THR, 16'd3);
    cfg_write(CFG_SLOW_SCALE, 16'd255);
    for (int k = CFG_UNUSED_FIRST; k <= CFG_UNUSED_LAST; k++)
      cfg_write(CFG_IDX_BITS'(k), 16'hFFFF);
    repeat (19) send_sample(1'b0, 1'b1, tx_gap());  // run the default gate down to 1
    send_sample(1'b0, 1'b1, tx_gap());  // low count, to mHz
    send_sample(1'b0, 1'b1, tx_gap());  // still low, reported again
    repeat (3) send_sample(1'b1, 1'b0, tx_gap());
    send_sample(1'b1, 1'b1, tx_gap());  // above high, back to Hz
    send_sample(1'b1, 1'b0, tx_gap());
    send_sample(1'b1, 1'b1, tx_gap());  // Hz measurement
    send_sample(1'b1, 1'b1, tx_gap());  // to mHz
    repeat (2) send_sample(1'b1, 1'b0, tx_gap());
    send_sample(1'b1, 1'b1, tx_gap());  // scaled mHz measurement
    send_sample(1'b0, 1'b0, tx_gap());
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_gate();
    int unsigned r;
    logic [7:0]  junk;
    r    = $urandom_range(0, 19);
    junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
    if (r == 0) return {junk, 8'd0};
    if (r == 1) return {junk, 8'd255};
    return {junk, 8'($urandom_range(1, 6))};
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_thr(input int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, span));
  endfunction

  task automatic test_random(input int unsigned phases, input int unsigned per_phase);
    int unsigned edge_pct;
    int unsigned tick_pct;
    for (int unsigned p = 0; p < phases; p++) begin
      drain();
      if (p == 0) begin
        cfg_write(CFG_FAST_GATE, 16'd255);
        cfg_write(CFG_SLOW_GATE, 16'hFFFF);
        cfg_write(CFG_LOW_THR, 16'hFFFF);
        cfg_write(CFG_HIGH_THR, 16'hFFFF);
        cfg_write(CFG_SLOW_SCALE, 16'd255);
      end else if (p == 1) begin
        cfg_write(CFG_FAST_GATE, 16'd1);
        cfg_write(CFG_SLOW_GATE, 16'd1);
        cfg_write(CFG_LOW_THR, 16'd0);
        cfg_write(CFG_HIGH_THR, 16'd0);
        cfg_write(CFG_SLOW_SCALE, 16'd1);
      end else begin
        cfg_write(CFG_FAST_GATE, pick_gate());
        cfg_write(CFG_SLOW_GATE, pick_gate());
        cfg_write(CFG_LOW_THR, pick_thr(8));
        cfg_write(CFG_HIGH_THR, pick_thr(10));
        cfg_write(CFG_SLOW_SCALE, {8'($urandom), 8'($urandom_range(1, 255))});
        if ($urandom_range(0, 3) == 0)
          cfg_write(CFG_IDX_BITS'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                    16'($urandom));
      end
      edge_pct = $urandom_range(0, 100);
      tick_pct = $urandom_range(10, 70);
      for (int unsigned i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) begin
          tx_quiet = ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        send_sample($urandom_range(0, 99) < edge_pct,
                    $urandom_range(0, 99) < tick_pct, tx_gap());
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_directed();
    test_random(8, 125);
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
